[src/mecanum_wheel_mixer_unit_assert.svh]
// Assertion macros shared by the checker of the mecanum wheel mixer.
`ifndef MECANUM_WHEEL_MIXER_UNIT_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MWM_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mwm_pkg.sv]
// Shared widths, constants and types of the mecanum wheel mixer.
package mwm_pkg;

    localparam int WHEELS      = 4;
    localparam int IN_W        = 8;
    localparam int POW_W       = 10;
    localparam int MAG_W       = 9;
    localparam int DB_W        = 7;
    localparam int SCALE_W     = 8;
    localparam int DUTY_W      = 8;
    localparam int PROD_W      = MAG_W + SCALE_W;
    localparam int NUM_W       = PROD_W + DUTY_W;
    localparam int DEN_W       = 16;
    localparam int Q_W         = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int FULL_DUTY   = 255;
    localparam int PCT_FULL    = 100;
    localparam int MIN_MAG     = 100;
    localparam int SCALE_RESET = 100;

    localparam int MIX_STAGES  = 3;
    localparam int DIV_STEPS   = 2;

    localparam int WHL_FL = 0;
    localparam int WHL_FR = 1;
    localparam int WHL_BL = 2;
    localparam int WHL_BR = 3;

    typedef logic signed [POW_W-1:0] t_pow;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [PROD_W-1:0]       t_prod;
    typedef logic [NUM_W-1:0]        t_num;
    typedef logic [DEN_W-1:0]        t_den;
    typedef logic [Q_W-1:0]          t_quo;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSLATE_DB = 2'd0,
        CFG_ROTATE_DB    = 2'd1,
        CFG_SPEED_SCALE  = 2'd2
    } t_cfg_idx;

endpackage

[src/mwm_mix.sv]
// Mixing, deadband test, normalization and dividend/divisor setup (three stages).
module mwm_mix (
    input  logic                                i_clk,
    input  logic [mwm_pkg::MIX_STAGES-1:0]      i_ld,
    input  logic signed [mwm_pkg::IN_W-1:0]     i_forward_speed,
    input  logic signed [mwm_pkg::IN_W-1:0]     i_sideways_speed,
    input  logic signed [mwm_pkg::IN_W-1:0]     i_rotate_speed,
    input  logic [mwm_pkg::DB_W-1:0]            i_translate_db,
    input  logic [mwm_pkg::DB_W-1:0]            i_rotate_db,
    input  logic [mwm_pkg::SCALE_W-1:0]         i_scale,
    output logic                                o_moving,
    output logic [mwm_pkg::WHEELS-1:0]          o_neg,
    output mwm_pkg::t_num                       o_num [mwm_pkg::WHEELS],
    output mwm_pkg::t_den                       o_den
);
    import mwm_pkg::*;

    function automatic logic [IN_W-1:0] abs_in(input logic [IN_W-1:0] v);
        abs_in = v[IN_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic t_mag abs_pow(input t_pow v);
        logic [POW_W-1:0] u;
        u = v;
        if (u[POW_W-1]) u = ~u + 1'b1;
        return u[MAG_W-1:0];
    endfunction

    function automatic t_mag max2(input t_mag a, input t_mag b);
        return (a > b) ? a : b;
    endfunction

    // Stage A: deadband test and the four wheel powers.
    t_pow                n_pow [WHEELS];
    logic                n_mov;
    t_pow                r_pow_a [WHEELS];
    logic                r_mov_a;

    always_comb begin
        t_pow y;
        t_pow x;
        t_pow r;
        y = t_pow'(i_forward_speed);
        x = t_pow'(i_sideways_speed);
        r = t_pow'(i_rotate_speed);
        n_mov = (abs_in(i_forward_speed)  > {1'b0, i_translate_db}) ||
                (abs_in(i_sideways_speed) > {1'b0, i_translate_db}) ||
                (abs_in(i_rotate_speed)   > {1'b0, i_rotate_db});
        n_pow[WHL_FL] = y + x + r;
        n_pow[WHL_FR] = y - x - r;
        n_pow[WHL_BL] = y - x + r;
        n_pow[WHL_BR] = y + x - r;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_pow_a <= n_pow;
            r_mov_a <= n_mov;
        end
    end

    // Stage B: magnitudes, floored maximum and magnitude times scale.
    t_mag                c_mag [WHEELS];
    t_mag                c_max;
    t_prod               n_prod [WHEELS];
    logic [WHEELS-1:0]   n_neg_b;
    t_prod               r_prod_b [WHEELS];
    t_mag                r_max_b;
    logic [WHEELS-1:0]   r_neg_b;
    logic                r_mov_b;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            c_mag[i]   = abs_pow(r_pow_a[i]);
            n_neg_b[i] = r_pow_a[i][POW_W-1];
            n_prod[i]  = t_prod'(c_mag[i]) * t_prod'(i_scale);
        end
        c_max = max2(max2(c_mag[WHL_FL], c_mag[WHL_FR]), max2(c_mag[WHL_BL], c_mag[WHL_BR]));
        c_max = max2(c_max, MAG_W'(MIN_MAG));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_prod_b <= n_prod;
            r_max_b  <= c_max;
            r_neg_b  <= n_neg_b;
            r_mov_b  <= r_mov_a;
        end
    end

    // Stage C: dividend is product times full duty, divisor is percent times maximum.
    t_num                n_num [WHEELS];
    t_den                n_den;
    t_num                r_num_c [WHEELS];
    t_den                r_den_c;
    logic [WHEELS-1:0]   r_neg_c;
    logic                r_mov_c;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            n_num[i] = (t_num'(r_prod_b[i]) << DUTY_W) - t_num'(r_prod_b[i]);
        end
        n_den = t_den'(r_max_b) * t_den'(PCT_FULL);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[2]) begin
            r_num_c <= n_num;
            r_den_c <= n_den;
            r_neg_c <= r_neg_b;
            r_mov_c <= r_mov_b;
        end
    end

    assign o_num    = r_num_c;
    assign o_den    = r_den_c;
    assign o_neg    = r_neg_c;
    assign o_moving = r_mov_c;

endmodule

[src/mwm_div.sv]
// Pipelined restoring divider for one wheel, STEPS quotient bits per stage.
module mwm_div #(
    parameter int STEPS  = mwm_pkg::DIV_STEPS,
    parameter int STAGES = (mwm_pkg::Q_W + STEPS - 1) / STEPS
) (
    input  logic                i_clk,
    input  logic [STAGES-1:0]   i_ld,
    input  mwm_pkg::t_num       i_num,
    input  mwm_pkg::t_den       i_den,
    input  logic                i_neg,
    output mwm_pkg::t_quo       o_quo,
    output logic                o_neg
);
    import mwm_pkg::*;

    t_num  c_rem_in [STAGES];
    t_den  c_den_in [STAGES];
    t_quo  c_quo_in [STAGES];
    logic  c_neg_in [STAGES];
    t_num  n_rem    [STAGES];
    t_quo  n_quo    [STAGES];
    t_num  r_rem    [STAGES-1];
    t_den  r_den    [STAGES-1];
    t_quo  r_quo    [STAGES];
    logic  r_neg    [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign c_rem_in[s] = i_num;
            assign c_den_in[s] = i_den;
            assign c_quo_in[s] = '0;
            assign c_neg_in[s] = i_neg;
        end else begin : g_next
            assign c_rem_in[s] = r_rem[s-1];
            assign c_den_in[s] = r_den[s-1];
            assign c_quo_in[s] = r_quo[s-1];
            assign c_neg_in[s] = r_neg[s-1];
        end

        // Each step tries the divisor shifted to the next lower quotient bit.
        always_comb begin
            t_num rem;
            t_quo quo;
            t_num sh;
            int   k;
            rem = c_rem_in[s];
            quo = c_quo_in[s];
            for (int j = 0; j < STEPS; j++) begin
                k = Q_W - 1 - s * STEPS - j;
                if (k >= 0) begin
                    sh = t_num'(c_den_in[s]) << k;
                    if (rem >= sh) begin
                        rem = rem - sh;
                        quo = {quo[Q_W-2:0], 1'b1};
                    end else begin
                        quo = {quo[Q_W-2:0], 1'b0};
                    end
                end
            end
            n_rem[s] = rem;
            n_quo[s] = quo;
        end

        always_ff @(posedge i_clk) begin
            if (i_ld[s]) begin
                r_quo[s] <= n_quo[s];
                r_neg[s] <= c_neg_in[s];
            end
        end

        if (s < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ld[s]) begin
                    r_rem[s] <= n_rem[s];
                    r_den[s] <= c_den_in[s];
                end
            end
        end
    end

    assign o_quo = r_quo[STAGES-1];
    assign o_neg = r_neg[STAGES-1];

endmodule

[src/mecanum_wheel_mixer_unit.sv]
// Top level of the mecanum wheel mixer: config registers, pipeline control, output stage.
//
//  Channel   | Valid / ready          | Payload
//  ----------+------------------------+------------------------------------------------
//  command   | i_valid / o_ready      | i_forward_speed, i_sideways_speed, i_rotate_speed
//  result    | o_valid / i_ready      | o_stopped, o_*_duty, o_*_reverse (four wheels)
//  config    | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
//  One command transfer per cycle is sustained while the result side is ready; each
//  command passes through the mixing stages, the restoring divider stages of each
//  wheel and the output register.
//  Reset clears the stage valid bits and loads the register defaults.
//  A stall on the result side backs up stage by stage; an empty stage still
//  takes a transfer, so bubbles are squeezed out and nothing is lost or repeated.
module mecanum_wheel_mixer_unit #(
    parameter int DIV_STEPS_PER_STAGE = mwm_pkg::DIV_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [mwm_pkg::IN_W-1:0]   i_forward_speed,
    input  logic signed [mwm_pkg::IN_W-1:0]   i_sideways_speed,
    input  logic signed [mwm_pkg::IN_W-1:0]   i_rotate_speed,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_stopped,
    output logic [mwm_pkg::DUTY_W-1:0]        o_front_left_duty,
    output logic                              o_front_left_reverse,
    output logic [mwm_pkg::DUTY_W-1:0]        o_front_right_duty,
    output logic                              o_front_right_reverse,
    output logic [mwm_pkg::DUTY_W-1:0]        o_back_left_duty,
    output logic                              o_back_left_reverse,
    output logic [mwm_pkg::DUTY_W-1:0]        o_back_right_duty,
    output logic                              o_back_right_reverse,
    input  logic                              i_cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mwm_pkg::*;

    localparam int DIV_STAGES = (Q_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
    localparam int LAST       = MIX_STAGES + DIV_STAGES;
    localparam int NSTG       = LAST + 1;

    // Config registers. User writes come only while the pipeline is idle; not enforced.
    logic [DB_W-1:0]     r_translate_db;
    logic [DB_W-1:0]     r_rotate_db;
    logic [SCALE_W-1:0]  r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_translate_db <= '0;
            r_rotate_db    <= '0;
            r_scale        <= SCALE_W'(SCALE_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRANSLATE_DB: r_translate_db <= i_cfg_data[DB_W-1:0];
                CFG_ROTATE_DB:    r_rotate_db    <= i_cfg_data[DB_W-1:0];
                CFG_SPEED_SCALE:  r_scale        <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline control. A stage can take a transfer when it is empty or when
    // the stage after it can; the ready chain runs back from the result port.
    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] c_rdy;
    logic [NSTG-1:0] c_vin;
    logic [NSTG-1:0] c_ld;

    always_comb begin
        c_rdy[NSTG-1] = !r_valid[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            c_rdy[k] = !r_valid[k] || c_rdy[k+1];
        end
    end

    assign c_vin = {r_valid[NSTG-2:0], i_valid};
    assign c_ld  = c_vin & c_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (r_valid & ~c_rdy) | (c_vin & c_rdy);
        end
    end

    assign o_ready = c_rdy[0];
    assign o_valid = r_valid[NSTG-1];

    // Mixing and divider setup.
    logic                w_moving;
    logic [WHEELS-1:0]   w_neg;
    t_num                w_num [WHEELS];
    t_den                w_den;

    mwm_mix u_mix (
        .i_clk            (i_clk),
        .i_ld             (c_ld[MIX_STAGES-1:0]),
        .i_forward_speed  (i_forward_speed),
        .i_sideways_speed (i_sideways_speed),
        .i_rotate_speed   (i_rotate_speed),
        .i_translate_db   (r_translate_db),
        .i_rotate_db      (r_rotate_db),
        .i_scale          (r_scale),
        .o_moving         (w_moving),
        .o_neg            (w_neg),
        .o_num            (w_num),
        .o_den            (w_den)
    );

    // One divider per wheel; all four share the stage load enables.
    t_quo                w_quo [WHEELS];
    logic [WHEELS-1:0]   w_neg_d;

    for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
        mwm_div #(
            .STEPS  (DIV_STEPS_PER_STAGE),
            .STAGES (DIV_STAGES)
        ) u_div (
            .i_clk (i_clk),
            .i_ld  (c_ld[LAST-1:MIX_STAGES]),
            .i_num (w_num[w]),
            .i_den (w_den),
            .i_neg (w_neg[w]),
            .o_quo (w_quo[w]),
            .o_neg (w_neg_d[w])
        );
    end

    // The moving flag rides alongside the divider stages.
    logic [DIV_STAGES-1:0] r_mov_d;
    logic [DIV_STAGES-1:0] c_mov_in;
    logic [DIV_STAGES-1:0] c_ld_d;

    assign c_mov_in = {r_mov_d[DIV_STAGES-2:0], w_moving};
    assign c_ld_d   = c_ld[LAST-1:MIX_STAGES];

    always_ff @(posedge i_clk) begin
        r_mov_d <= (r_mov_d & ~c_ld_d) | (c_mov_in & c_ld_d);
    end

    // Output stage: saturate each quotient at full duty, and force a stopped
    // command to zero duty and forward direction on every wheel.
    logic                r_stopped;
    logic [DUTY_W-1:0]   r_duty [WHEELS];
    logic [WHEELS-1:0]   r_rev;
    logic [DUTY_W-1:0]   n_duty [WHEELS];
    logic                c_mov;

    assign c_mov = r_mov_d[DIV_STAGES-1];

    always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
            if (!c_mov) begin
                n_duty[w] = '0;
            end else if (|w_quo[w][Q_W-1:DUTY_W]) begin
                n_duty[w] = DUTY_W'(FULL_DUTY);
            end else begin
                n_duty[w] = w_quo[w][DUTY_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ld[LAST]) begin
            r_stopped <= !c_mov;
            r_duty    <= n_duty;
            r_rev     <= w_neg_d & {WHEELS{c_mov}};
        end
    end

    assign o_stopped             = r_stopped;
    assign o_front_left_duty     = r_duty[WHL_FL];
    assign o_front_left_reverse  = r_rev[WHL_FL];
    assign o_front_right_duty    = r_duty[WHL_FR];
    assign o_front_right_reverse = r_rev[WHL_FR];
    assign o_back_left_duty      = r_duty[WHL_BL];
    assign o_back_left_reverse   = r_rev[WHL_BL];
    assign o_back_right_duty     = r_duty[WHL_BR];
    assign o_back_right_reverse  = r_rev[WHL_BR];

endmodule

[src/mwm_checker.sv]
// Port-level checker of the mecanum wheel mixer and its bind to the top level.
`include "mecanum_wheel_mixer_unit_assert.svh"

module mwm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_stopped,
    input logic [mwm_pkg::DUTY_W-1:0]  o_front_left_duty,
    input logic                        o_front_left_reverse,
    input logic [mwm_pkg::DUTY_W-1:0]  o_front_right_duty,
    input logic                        o_front_right_reverse,
    input logic [mwm_pkg::DUTY_W-1:0]  o_back_left_duty,
    input logic                        o_back_left_reverse,
    input logic [mwm_pkg::DUTY_W-1:0]  o_back_right_duty,
    input logic                        o_back_right_reverse
);

    // A waiting result keeps its duties.
    `MWM_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_front_left_duty) && $stable(o_front_right_duty) && $stable(o_back_left_duty) && $stable(o_back_right_duty), "result changed while stalled")

    // A stopped result drives every wheel at zero, forward.
    `MWM_ASSERT_IMP(a_stop_zero, i_clk, i_rst_n, o_valid && o_stopped, (o_front_left_duty == '0) && (o_front_right_duty == '0) && (o_back_left_duty == '0) && (o_back_right_duty == '0) && !o_front_left_reverse && !o_front_right_reverse && !o_back_left_reverse && !o_back_right_reverse, "stopped result with wheel drive")

    // With the output stage empty the whole pipeline can move.
    `MWM_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready, "command side stalled with empty output")

    // Reset empties the pipeline.
    `MWM_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n, !o_valid, "result valid after reset")

endmodule

bind mecanum_wheel_mixer_unit mwm_checker u_mwm_checker (.*);
